// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_AT checks a property at every rising clock edge, held off in reset.
// ASSERT_ALWAYS checks a plain condition at every rising clock edge, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/bfrm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded FIFO with running mean: shared types and constants
// Word layouts of both channels, operation and status codes, sequencer states.
// -----------------------------------------------------------------------------
package bfrm_pkg;

    localparam int ID_W   = 10;
    localparam int RATE_W = 8;
    localparam int OCC_W  = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ID_W-1:0]   entry_id;
        logic [RATE_W-1:0] capture_rate;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic              evicted;
        logic [ID_W-1:0]   removed_id;
        logic [RATE_W-1:0] removed_rate;
        logic [OCC_W-1:0]  occupancy;
        logic [RATE_W-1:0] mean_rate;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } t_state;

endpackage

// ===== sv/bounded_fifo_with_running_mean_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded FIFO with running mean
// Ring store of up to DEPTH id/rate entries that drops its oldest entry when an
// insert finds it full, answering every word with occupancy and rounded mean.
//
//   channel  | valid        | stall        | word
//   ---------+--------------+--------------+-------------
//   input    | i_in_valid   | o_in_stall   | i_in_word
//   output   | o_out_valid  | i_out_stall  | o_out_word
//
// A word is accepted in the idle cycle, which also reads the oldest entry from
// the ring memory; the next cycle updates count and sum and writes an inserted
// entry at the tail, and the one after forms the mean by reciprocal multiply
// and loads the result register. One word is in flight at a time, so no new
// word is taken until the result register is loaded; a stalled result holds
// the block in its last cycle until the result register frees.
// Reset clears pointers, count and sum at once; the memory needs no clearing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_fifo_with_running_mean_top #(
    parameter int DEPTH   = 5,
    parameter int ID_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bfrm_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bfrm_pkg::t_out_word   o_out_word
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = bfrm_pkg::RATE_W + CNT_W;
    localparam int NUM_W  = $clog2(511 * DEPTH + 1);
    // Reciprocal scale chosen so that 2^K exceeds numerator times divisor.
    localparam int K      = $clog2(1022 * DEPTH * DEPTH) + 1;
    localparam int PROD_W = NUM_W + K;
    localparam int IDX_W  = (ID_BITS > bfrm_pkg::ID_W) ? ID_BITS : bfrm_pkg::ID_W;
    localparam int ENT_W  = ID_BITS + bfrm_pkg::RATE_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    // ---------------------------------------------------------------- tables
    logic [K-1:0] w_recip [0:2**CNT_W-1];

    for (genvar g = 0; g < 2**CNT_W; g++) begin : g_recip
        if (g == 0 || g > DEPTH) begin : g_zero
            assign w_recip[g] = '0;
        end else begin : g_val
            localparam logic [K:0] RC =
                (K+1)'(((64'd1 << K) + 64'(2 * g) - 64'd1) / 64'(2 * g));
            assign w_recip[g] = RC[K-1:0];
        end
    end

    // ---------------------------------------------------------------- state
    bfrm_pkg::t_state     r_state, n_state;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic                 r_out_valid;

    bfrm_pkg::t_in_word   r_in;
    logic [ENT_W-1:0]     r_rd;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [K-1:0]         r_recip;
    logic                 r_status, n_status;
    logic                 r_evicted, n_evicted;
    logic [bfrm_pkg::ID_W-1:0]   r_rem_id, n_rem_id;
    logic [bfrm_pkg::RATE_W-1:0] r_rem_rate, n_rem_rate;
    bfrm_pkg::t_out_word  r_out;

    logic [ENT_W-1:0]     mem [0:DEPTH-1];

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_load_out;
    logic                 w_push;
    logic                 w_pop;
    logic [IDX_W-1:0]     w_in_id_ext;
    logic [IDX_W-1:0]     w_rd_id_ext;
    logic [ID_BITS-1:0]   w_rd_id;
    logic [bfrm_pkg::RATE_W-1:0] w_rd_rate;
    logic [PROD_W-1:0]    w_prod;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != bfrm_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == bfrm_pkg::ST_IDLE);
    assign w_in_id_ext = IDX_W'(r_in.entry_id);
    assign w_rd_id     = r_rd[ENT_W-1 -: ID_BITS];
    assign w_rd_rate   = r_rd[bfrm_pkg::RATE_W-1:0];
    assign w_rd_id_ext = IDX_W'(w_rd_id);
    assign w_prod      = PROD_W'(r_num) * PROD_W'(r_recip);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_sum      = r_sum;
        n_num      = r_num;
        n_status   = r_status;
        n_evicted  = r_evicted;
        n_rem_id   = r_rem_id;
        n_rem_rate = r_rem_rate;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_load_out = 1'b0;

        case (r_state)
            bfrm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bfrm_pkg::ST_UPDATE;
                end
            end
            bfrm_pkg::ST_UPDATE: begin
                w_push = (r_in.opcode == bfrm_pkg::OP_INSERT);
                // A remove pops a non-empty store; an insert pops only when full.
                w_pop  = w_push ? (r_count == FULL_CNT) : (r_count != '0);

                if (w_pop) begin
                    n_head     = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                    n_rem_id   = w_rd_id_ext[bfrm_pkg::ID_W-1:0];
                    n_rem_rate = w_rd_rate;
                end else begin
                    n_rem_id   = '0;
                    n_rem_rate = '0;
                end
                if (w_push) begin
                    n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                end

                n_count = r_count - CNT_W'(w_pop) + CNT_W'(w_push);
                n_sum   = r_sum
                        - (w_pop  ? SUM_W'(w_rd_rate)          : '0)
                        + (w_push ? SUM_W'(r_in.capture_rate) : '0);
                n_num   = NUM_W'({n_sum, 1'b0}) + NUM_W'(n_count);

                n_status  = (!w_push && r_count == '0) ? bfrm_pkg::STATUS_EMPTY
                                                        : bfrm_pkg::STATUS_OK;
                n_evicted = w_push && w_pop;
                n_state   = bfrm_pkg::ST_DIVIDE;
            end
            bfrm_pkg::ST_DIVIDE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = bfrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfrm_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_sum   <= n_sum;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_word;
        end
        r_num      <= n_num;
        r_status   <= n_status;
        r_evicted  <= n_evicted;
        r_rem_id   <= n_rem_id;
        r_rem_rate <= n_rem_rate;
        if (r_state == bfrm_pkg::ST_UPDATE) begin
            r_recip <= w_recip[n_count];
        end
        if (w_load_out) begin
            r_out.status       <= r_status;
            r_out.evicted      <= r_evicted;
            r_out.removed_id   <= r_rem_id;
            r_out.removed_rate <= r_rem_rate;
            r_out.occupancy    <= bfrm_pkg::OCC_W'(r_count);
            r_out.mean_rate    <= w_prod[K +: bfrm_pkg::RATE_W];
        end
    end

    // The oldest entry is read as the word is accepted; the write-back at the
    // tail lands in the next cycle, before any following word can read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= mem[r_head];
        end
        if (w_push) begin
            mem[r_tail] <= {w_in_id_ext[ID_BITS-1:0], r_in.capture_rate};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---------------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "count above depth")
    `ASSERT_ALWAYS(a_sum_bound, i_clk, i_rst_n, 32'(r_sum) <= 32'(r_count) * 32'd255, "sum too big")
    `ASSERT_AT(a_result_out, i_clk, i_rst_n, w_load_out |=> o_out_valid, "result not shown")
    `ASSERT_AT(a_empty_sum, i_clk, i_rst_n, r_count == '0 |-> r_sum == '0, "empty with sum")
    `ASSERT_AT(a_empty_ptr, i_clk, i_rst_n, r_count == '0 |-> r_head == r_tail, "pointers apart")

endmodule

// ===== sim/fifo_mean_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded FIFO with running mean: result checker
// Watches both channels of the block. Every accepted input word is run through
// a private copy of the ring store to form the expected result word; every
// accepted output word is compared, field by field, with the oldest of those.
// -----------------------------------------------------------------------------
module fifo_mean_checker #(
    parameter int DEPTH = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bfrm_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bfrm_pkg::t_out_word i_out_word,
    output int                  o_pending,
    output int                  o_fail_count
);

    logic [bfrm_pkg::ID_W-1:0]   id_ring   [DEPTH];
    logic [bfrm_pkg::RATE_W-1:0] rate_ring [DEPTH];
    int unsigned       head_idx   = 0;
    int unsigned       tail_idx   = 0;
    int unsigned       fill       = 0;
    int unsigned       rate_total = 0;

    bfrm_pkg::t_out_word expected_q [$];
    int        mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void drop_oldest(inout bfrm_pkg::t_out_word r);
        r.removed_id   = id_ring[head_idx];
        r.removed_rate = rate_ring[head_idx];
        rate_total     = rate_total - rate_ring[head_idx];
        fill           = fill - 1;
        head_idx       = (head_idx + 1 == DEPTH) ? 0 : head_idx + 1;
    endfunction

    // Applies one input word to the private store and returns the result it causes.
    function automatic bfrm_pkg::t_out_word advance_store(input bfrm_pkg::t_in_word w);
        bfrm_pkg::t_out_word r;
        r        = '0;
        r.status = bfrm_pkg::STATUS_OK;
        if (w.opcode == bfrm_pkg::OP_REMOVE) begin
            if (fill == 0) begin
                r.status = bfrm_pkg::STATUS_EMPTY;
            end else begin
                drop_oldest(r);
            end
        end else begin
            if (fill == DEPTH) begin
                drop_oldest(r);
                r.evicted = 1'b1;
            end
            id_ring[tail_idx]   = w.entry_id;
            rate_ring[tail_idx] = w.capture_rate;
            tail_idx            = (tail_idx + 1 == DEPTH) ? 0 : tail_idx + 1;
            rate_total          = rate_total + w.capture_rate;
            fill                = fill + 1;
        end
        r.occupancy = bfrm_pkg::OCC_W'(fill);
        if (fill != 0) begin
            // Half up: add half the divisor before the division.
            r.mean_rate = bfrm_pkg::RATE_W'((2 * rate_total + fill) / (2 * fill));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        bfrm_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            head_idx   = 0;
            tail_idx   = 0;
            fill       = 0;
            rate_total = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h arrived with none expected",
                                              i_out_word));
                end else begin
                    exp_w = expected_q.pop_front();
                    if (i_out_word.status !== exp_w.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_word.status, exp_w.status));
                    if (i_out_word.evicted !== exp_w.evicted)
                        report_mismatch($sformatf("evicted %0d, expected %0d",
                                                  i_out_word.evicted, exp_w.evicted));
                    if (i_out_word.removed_id !== exp_w.removed_id)
                        report_mismatch($sformatf("removed_id %0d, expected %0d",
                                                  i_out_word.removed_id, exp_w.removed_id));
                    if (i_out_word.removed_rate !== exp_w.removed_rate)
                        report_mismatch($sformatf("removed_rate %0d, expected %0d",
                                                  i_out_word.removed_rate, exp_w.removed_rate));
                    if (i_out_word.occupancy !== exp_w.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  i_out_word.occupancy, exp_w.occupancy));
                    if (i_out_word.mean_rate !== exp_w.mean_rate)
                        report_mismatch($sformatf("mean_rate %0d, expected %0d",
                                                  i_out_word.mean_rate, exp_w.mean_rate));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(advance_store(i_in_word));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/bounded_fifo_with_running_mean_top_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bounded FIFO with running mean: testbench top
// Drives a short directed sequence through empty, full and eviction cases,
// then biased random insert and remove words under four idling regimes on
// both channels. The checker predicts and compares; this module gives the verdict.
// -----------------------------------------------------------------------------
module bounded_fifo_with_running_mean_top_tb;

    localparam int DEPTH         = 5;
    localparam int RANDOM_WORDS  = 1250;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    bfrm_pkg::t_in_word  i_in_word   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    bfrm_pkg::t_out_word o_out_word;

    int pending;
    int fail_count;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int cycle_count = 0;

    always #6 i_clk = ~i_clk;

    bounded_fifo_with_running_mean_top #(
        .DEPTH   (DEPTH),
        .ID_BITS (bfrm_pkg::ID_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    fifo_mean_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bounded_fifo_with_running_mean_top_tb NOT OK");
            $finish;
        end
    end

    // Offers one word, after a random gap, and returns once it has been taken.
    // Valid is left high so that a following word goes out without a bubble.
    task automatic send_word(input logic op, input logic [bfrm_pkg::ID_W-1:0] id,
                             input logic [bfrm_pkg::RATE_W-1:0] rate);
        bfrm_pkg::t_in_word w;
        w.opcode       = op;
        w.entry_id     = id;
        w.capture_rate = rate;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [bfrm_pkg::RATE_W-1:0] pick_rate();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return bfrm_pkg::RATE_W'($urandom_range(255));
    endfunction

    task automatic run_random(input int count);
        int insert_bias;
        insert_bias = 50;
        for (int k = 0; k < count; k++) begin
            // Bursts that lean towards filling or emptying reach both ends of the store.
            if (k % 30 == 0) begin
                case ($urandom_range(2))
                    0: insert_bias = 80;
                    1: insert_bias = 25;
                    default: insert_bias = 50;
                endcase
            end
            send_word(($urandom_range(99) < insert_bias) ? bfrm_pkg::OP_INSERT
                                                         : bfrm_pkg::OP_REMOVE,
                      bfrm_pkg::ID_W'($urandom_range(1023)), pick_rate());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty removes, field extremes, filling, eviction, rounding.
        send_word(bfrm_pkg::OP_REMOVE, 10'h3FF, 8'hFF);
        send_word(bfrm_pkg::OP_INSERT, 10'h000, 8'h00);
        send_word(bfrm_pkg::OP_INSERT, 10'h3FF, 8'hFF);
        send_word(bfrm_pkg::OP_REMOVE, 10'h000, 8'h00);
        send_word(bfrm_pkg::OP_REMOVE, 10'h3FF, 8'hFF);
        send_word(bfrm_pkg::OP_REMOVE, 10'h155, 8'hAA);
        send_word(bfrm_pkg::OP_INSERT, 10'h155, 8'hAA);
        send_word(bfrm_pkg::OP_INSERT, 10'h2AA, 8'h55);
        send_word(bfrm_pkg::OP_INSERT, 10'h3FF, 8'hFF);
        send_word(bfrm_pkg::OP_INSERT, 10'h3FE, 8'hFF);
        send_word(bfrm_pkg::OP_INSERT, 10'h000, 8'h00);
        send_word(bfrm_pkg::OP_INSERT, 10'h3FF, 8'h01);
        send_word(bfrm_pkg::OP_INSERT, 10'h001, 8'hFE);
        for (int k = 0; k < DEPTH; k++)
            send_word(bfrm_pkg::OP_REMOVE, 10'h000, 8'h00);
        send_word(bfrm_pkg::OP_REMOVE, 10'h000, 8'h00);
        // A mean of exactly one and a half must round up.
        send_word(bfrm_pkg::OP_INSERT, 10'h011, 8'h01);
        send_word(bfrm_pkg::OP_INSERT, 10'h022, 8'h02);
        send_word(bfrm_pkg::OP_REMOVE, 10'h000, 8'h00);
        send_word(bfrm_pkg::OP_REMOVE, 10'h000, 8'h00);

        run_random(RANDOM_WORDS / 4);
        gap_pct   = 50;
        stall_pct = 0;
        run_random(RANDOM_WORDS / 4);
        gap_pct   = 0;
        stall_pct = 50;
        run_random(RANDOM_WORDS / 4);
        gap_pct   = 17;
        stall_pct = 17;
        run_random(RANDOM_WORDS / 4);
        i_in_valid <= 1'b0;

        // The pending count is registered, so the last word shows up in it only after the next edge.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_fifo_with_running_mean_top_tb OK");
        end else begin
            $display("bounded_fifo_with_running_mean_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bfrm_pkg.sv
sv/bounded_fifo_with_running_mean_top.sv
sim/fifo_mean_checker.sv
sim/bounded_fifo_with_running_mean_top_tb.sv
